// ----- sv/occupancy_grid_shape_rasterizer_assert.svh -----
// Assertion macros used by the rasterizer back end.
`ifndef OCCUPANCY_GRID_SHAPE_RASTERIZER_ASSERT_SVH
`define OCCUPANCY_GRID_SHAPE_RASTERIZER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define OGSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ogsr assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define OGSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ogsr assertion failed");

`endif

// ----- sv/ogsr_pkg.sv -----
package ogsr_pkg;

    // Grid capacity.
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB_W     = $clog2(MAX_COLS + 1);
    localparam int RB_W     = $clog2(MAX_ROWS + 1);
    localparam int GRID_W   = (COL_W > ROW_W) ? COL_W : ROW_W;

    // Field widths.
    localparam int MODE_W  = 2;
    localparam int CRD_W   = 24;
    localparam int HALF_W  = 23;
    localparam int LAYER_W = 32;
    localparam int SEL_W   = 6;
    localparam int CS_W    = 20;
    localparam int SIZE_W  = 7;

    // Arithmetic widths.
    localparam int REL_W  = CRD_W + 1;
    localparam int SUM_W  = REL_W + 1;
    localparam int NUM_W  = REL_W;
    localparam int POS_W  = CS_W + GRID_W;
    localparam int D_W    = POS_W + 2;
    localparam int DM_W   = D_W - 1;
    localparam int SQ_W   = 2 * DM_W;
    localparam int R2_W   = 2 * HALF_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
    localparam logic [2:0] REG_WIDTH      = 3'd3;
    localparam logic [2:0] REG_HEIGHT     = 3'd4;
    localparam logic [2:0] REG_LAYER_MASK = 3'd5;

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHAPE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SHAPE,
        OP_READ,
        OP_NULL
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic                      circle;
        logic signed [REL_W-1:0]   rx;
        logic signed [REL_W-1:0]   ry;
        logic        [HALF_W-1:0]  ex;
        logic        [HALF_W-1:0]  ey;
        logic        [COL_W-1:0]   col;
        logic        [ROW_W-1:0]   row;
    } t_item;

    typedef struct packed {
        logic signed [CRD_W-1:0]   origin_x;
        logic signed [CRD_W-1:0]   origin_y;
        logic        [CS_W-1:0]    cell_size;
        logic        [CB_W-1:0]    cols;
        logic        [RB_W-1:0]    rows;
        logic        [LAYER_W-1:0] layer_mask;
    } t_cfg;

    typedef struct packed {
        logic blocked;
        logic applied;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_BOUNDS,
        S_ROW_START,
        S_CELL_D,
        S_CELL_SQ,
        S_CELL_CMP,
        S_ROW_RD,
        S_ROW_WR,
        S_READ,
        S_DONE
    } t_state;

endpackage

// ----- sv/ogsr_div.sv -----
module ogsr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ogsr_pkg::NUM_W-1:0]   i_num,
    input  logic [ogsr_pkg::CS_W-1:0]    i_den,
    output logic                         o_done,
    output logic [ogsr_pkg::NUM_W-1:0]   o_quot,
    output logic                         o_rem_nz
);

    logic                          r_busy;
    logic                          r_done;
    logic [ogsr_pkg::DCNT_W-1:0]   r_cnt;
    logic [ogsr_pkg::NUM_W-1:0]    r_quo;
    logic [ogsr_pkg::CS_W-1:0]     r_rem;
    logic [ogsr_pkg::CS_W:0]       trial;
    logic [ogsr_pkg::CS_W:0]       diff;
    logic                          ge;

    // One restoring step: bring down the next numerator bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quo[ogsr_pkg::NUM_W-1]};
        ge    = trial >= {1'b0, i_den};
        diff  = trial - {1'b0, i_den};
    end

    // Control: count the steps and flag the end of a division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= (ogsr_pkg::DCNT_W)'(ogsr_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - (ogsr_pkg::DCNT_W)'(1);
                if (r_cnt == (ogsr_pkg::DCNT_W)'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in behind the numerator bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ogsr_pkg::NUM_W-2:0], ge};
            r_rem <= ge ? diff[ogsr_pkg::CS_W-1:0] : trial[ogsr_pkg::CS_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quo;
    assign o_rem_nz = |r_rem;

endmodule

// ----- sv/ogsr_front.sv -----
module ogsr_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ogsr_pkg::t_cfg                   i_cfg,
    input  logic                             i_push,
    input  logic [ogsr_pkg::MODE_W-1:0]      i_mode,
    input  logic                             i_shape_kind,
    input  logic signed [ogsr_pkg::CRD_W-1:0] i_center_x,
    input  logic signed [ogsr_pkg::CRD_W-1:0] i_center_y,
    input  logic [ogsr_pkg::HALF_W-1:0]      i_half_x,
    input  logic [ogsr_pkg::HALF_W-1:0]      i_half_y,
    input  logic [ogsr_pkg::LAYER_W-1:0]     i_layer,
    input  logic [ogsr_pkg::SEL_W-1:0]       i_cell_col,
    input  logic [ogsr_pkg::SEL_W-1:0]       i_cell_row,
    output logic                             o_full,
    output logic                             o_valid,
    output ogsr_pkg::t_item                  o_item,
    input  logic                             i_pop
);

    ogsr_pkg::t_item n_item;
    ogsr_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            do_push;
    logic            do_pop;
    logic            in_grid;

    // Classify the incoming transaction and place the shape relative to the grid.
    always_comb begin
        in_grid = (int'(i_cell_col) < int'(i_cfg.cols)) &&
                  (int'(i_cell_row) < int'(i_cfg.rows));
        n_item.circle = i_shape_kind;
        n_item.rx  = (ogsr_pkg::REL_W)'(i_center_x) - (ogsr_pkg::REL_W)'(i_cfg.origin_x);
        n_item.ry  = (ogsr_pkg::REL_W)'(i_center_y) - (ogsr_pkg::REL_W)'(i_cfg.origin_y);
        n_item.ex  = i_half_x;
        n_item.ey  = i_shape_kind ? i_half_x : i_half_y;
        n_item.col = (ogsr_pkg::COL_W)'(i_cell_col);
        n_item.row = (ogsr_pkg::ROW_W)'(i_cell_row);
        unique case (i_mode)
            ogsr_pkg::MODE_CLEAR: begin
                n_item.op = ogsr_pkg::OP_CLEAR;
            end
            ogsr_pkg::MODE_SHAPE: begin
                n_item.op = ((i_layer & i_cfg.layer_mask) != '0) ?
                            ogsr_pkg::OP_SHAPE : ogsr_pkg::OP_NULL;
            end
            ogsr_pkg::MODE_READ: begin
                n_item.op = in_grid ? ogsr_pkg::OP_READ : ogsr_pkg::OP_NULL;
            end
            default: begin
                n_item.op = ogsr_pkg::OP_NULL;
            end
        endcase
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Two-entry queue towards the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= n_item;
        end
    end

endmodule

// ----- sv/ogsr_back.sv -----
`include "occupancy_grid_shape_rasterizer_assert.svh"

module ogsr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ogsr_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  ogsr_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_res_push,
    output ogsr_pkg::t_res   o_res,
    input  logic             i_res_full
);

    ogsr_pkg::t_state r_state;
    ogsr_pkg::t_state n_state;
    ogsr_pkg::t_item  r_item;
    ogsr_pkg::t_res   r_res;

    logic [1:0]                         r_div_idx;
    logic                               r_div_start;
    logic                               r_empty;
    logic [ogsr_pkg::CB_W-1:0]          r_min_c, r_max_c, r_c;
    logic [ogsr_pkg::RB_W-1:0]          r_min_r, r_max_r, r_r;
    logic [ogsr_pkg::POS_W-1:0]         r_x0, r_y0, r_x0_first;
    logic [ogsr_pkg::R2_W-1:0]          r_r2;
    logic [ogsr_pkg::DM_W-1:0]          r_dx, r_dy;
    logic [ogsr_pkg::SQ_W-1:0]          r_dx2, r_dy2;
    logic [ogsr_pkg::MAX_COLS-1:0]      r_mask;
    logic [ogsr_pkg::MAX_ROWS-1:0]      r_valid;
    logic [ogsr_pkg::MAX_COLS-1:0]      r_rd_data;
    logic [ogsr_pkg::MAX_COLS-1:0]      mem [ogsr_pkg::MAX_ROWS];

    logic                               div_done;
    logic [ogsr_pkg::NUM_W-1:0]         div_quot;
    logic                               div_rem_nz;
    logic signed [ogsr_pkg::REL_W-1:0]  rel;
    logic [ogsr_pkg::HALF_W-1:0]        half;
    logic signed [ogsr_pkg::SUM_W-1:0]  rel_e, half_e, num_s;
    logic [ogsr_pkg::NUM_W-1:0]         num_mag;
    logic                               num_neg, num_zero, up_empty;
    logic [ogsr_pkg::NUM_W:0]           up_v;
    logic [ogsr_pkg::CB_W-1:0]          lo_c, hi_c;
    logic [ogsr_pkg::RB_W-1:0]          lo_r, hi_r;
    logic                               bounds_empty;
    logic [ogsr_pkg::MAX_COLS-1:0]      box_mask;
    logic signed [ogsr_pkg::D_W-1:0]    xs, xe, ys, ye, rxs, rys, dx, dy;
    logic [ogsr_pkg::DIST_W-1:0]        dist_sq;
    logic                               hit;
    logic                               last_col, last_row;
    logic [ogsr_pkg::ROW_W-1:0]         rd_addr;

    // Divider for the four cell bounds.
    ogsr_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_start),
        .i_num    (num_mag),
        .i_den    (i_cfg.cell_size),
        .o_done   (div_done),
        .o_quot   (div_quot),
        .o_rem_nz (div_rem_nz)
    );

    // Numerator of the current bound: even index lower edge, odd index upper edge.
    always_comb begin
        rel      = r_div_idx[1] ? r_item.ry : r_item.rx;
        half     = r_div_idx[1] ? r_item.ey : r_item.ex;
        rel_e    = (ogsr_pkg::SUM_W)'(rel);
        half_e   = signed'((ogsr_pkg::SUM_W)'(half));
        num_s    = r_div_idx[0] ? rel_e + half_e : rel_e - half_e;
        num_neg  = num_s[ogsr_pkg::SUM_W-1];
        num_zero = num_s == '0;
        num_mag  = num_neg ? (ogsr_pkg::NUM_W)'(-num_s) : (ogsr_pkg::NUM_W)'(num_s);
    end

    // Turn quotient and remainder into floor and ceil-minus-one, clamped to the grid.
    always_comb begin
        up_v     = {1'b0, div_quot} + (ogsr_pkg::NUM_W + 1)'(div_rem_nz)
                   - (ogsr_pkg::NUM_W + 1)'(1);
        up_empty = num_neg || num_zero;
        lo_c = num_neg ? '0 :
               ((div_quot >= (ogsr_pkg::NUM_W)'(ogsr_pkg::MAX_COLS)) ?
                (ogsr_pkg::CB_W)'(ogsr_pkg::MAX_COLS) : (ogsr_pkg::CB_W)'(div_quot));
        lo_r = num_neg ? '0 :
               ((div_quot >= (ogsr_pkg::NUM_W)'(ogsr_pkg::MAX_ROWS)) ?
                (ogsr_pkg::RB_W)'(ogsr_pkg::MAX_ROWS) : (ogsr_pkg::RB_W)'(div_quot));
        hi_c = (up_v >= (ogsr_pkg::NUM_W + 1)'(i_cfg.cols)) ?
               (ogsr_pkg::CB_W)'(i_cfg.cols - (ogsr_pkg::CB_W)'(1)) :
               (ogsr_pkg::CB_W)'(up_v);
        hi_r = (up_v >= (ogsr_pkg::NUM_W + 1)'(i_cfg.rows)) ?
               (ogsr_pkg::RB_W)'(i_cfg.rows - (ogsr_pkg::RB_W)'(1)) :
               (ogsr_pkg::RB_W)'(up_v);
        bounds_empty = r_empty || (r_min_c > r_max_c) || (r_min_r > r_max_r) ||
                       (i_cfg.cols == '0) || (i_cfg.rows == '0);
    end

    // Row mask of a box: every column inside the bounds.
    always_comb begin
        for (int i = 0; i < ogsr_pkg::MAX_COLS; i++) begin
            box_mask[i] = ((ogsr_pkg::CB_W)'(i) >= r_min_c) &&
                          ((ogsr_pkg::CB_W)'(i) <= r_max_c);
        end
    end

    // Distance from the centre to the nearest point of the current cell.
    always_comb begin
        xs  = signed'((ogsr_pkg::D_W)'(r_x0));
        ys  = signed'((ogsr_pkg::D_W)'(r_y0));
        xe  = xs + signed'((ogsr_pkg::D_W)'(i_cfg.cell_size));
        ye  = ys + signed'((ogsr_pkg::D_W)'(i_cfg.cell_size));
        rxs = (ogsr_pkg::D_W)'(r_item.rx);
        rys = (ogsr_pkg::D_W)'(r_item.ry);
        dx  = (rxs < xs) ? xs - rxs : ((rxs > xe) ? rxs - xe : '0);
        dy  = (rys < ys) ? ys - rys : ((rys > ye) ? rys - ye : '0);
        dist_sq = (ogsr_pkg::DIST_W)'(r_dx2) + (ogsr_pkg::DIST_W)'(r_dy2);
        hit  = dist_sq <= (ogsr_pkg::DIST_W)'(r_r2);
        last_col = r_c == r_max_c;
        last_row = r_r == r_max_r;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ogsr_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.op)
                        ogsr_pkg::OP_CLEAR: n_state = ogsr_pkg::S_DONE;
                        ogsr_pkg::OP_NULL:  n_state = ogsr_pkg::S_DONE;
                        ogsr_pkg::OP_READ:  n_state = ogsr_pkg::S_READ;
                        ogsr_pkg::OP_SHAPE: n_state = ogsr_pkg::S_DIV;
                        default:            n_state = ogsr_pkg::S_DONE;
                    endcase
                end
            end
            ogsr_pkg::S_DIV: begin
                if (div_done && r_div_idx == 2'd3) begin
                    n_state = ogsr_pkg::S_BOUNDS;
                end
            end
            ogsr_pkg::S_BOUNDS: begin
                n_state = bounds_empty ? ogsr_pkg::S_DONE : ogsr_pkg::S_ROW_START;
            end
            ogsr_pkg::S_ROW_START: begin
                n_state = r_item.circle ? ogsr_pkg::S_CELL_D : ogsr_pkg::S_ROW_RD;
            end
            ogsr_pkg::S_CELL_D:   n_state = ogsr_pkg::S_CELL_SQ;
            ogsr_pkg::S_CELL_SQ:  n_state = ogsr_pkg::S_CELL_CMP;
            ogsr_pkg::S_CELL_CMP: begin
                n_state = last_col ? ogsr_pkg::S_ROW_RD : ogsr_pkg::S_CELL_D;
            end
            ogsr_pkg::S_ROW_RD:   n_state = ogsr_pkg::S_ROW_WR;
            ogsr_pkg::S_ROW_WR: begin
                n_state = last_row ? ogsr_pkg::S_DONE : ogsr_pkg::S_ROW_START;
            end
            ogsr_pkg::S_READ:     n_state = ogsr_pkg::S_DONE;
            ogsr_pkg::S_DONE: begin
                if (!i_res_full) begin
                    n_state = ogsr_pkg::S_IDLE;
                end
            end
            default: n_state = ogsr_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop      = (r_state == ogsr_pkg::S_IDLE) && i_valid;
        o_res_push = (r_state == ogsr_pkg::S_DONE) && !i_res_full;
        o_res      = r_res;
        rd_addr    = (r_state == ogsr_pkg::S_IDLE) ? i_item.row :
                     r_r[ogsr_pkg::ROW_W-1:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ogsr_pkg::S_IDLE;
            r_div_start <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (o_pop && i_item.op == ogsr_pkg::OP_SHAPE) ||
                           (r_state == ogsr_pkg::S_DIV && div_done && r_div_idx != 2'd3);
            if (o_pop && i_item.op == ogsr_pkg::OP_CLEAR) begin
                r_valid <= '0;
            end else if (r_state == ogsr_pkg::S_ROW_WR) begin
                r_valid[r_r[ogsr_pkg::ROW_W-1:0]] <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ogsr_pkg::S_IDLE: begin
                r_item      <= i_item;
                r_div_idx   <= 2'd0;
                r_empty     <= 1'b0;
                r_res.blocked <= 1'b0;
                r_res.applied <= i_item.op == ogsr_pkg::OP_SHAPE;
            end
            ogsr_pkg::S_DIV: begin
                if (div_done) begin
                    r_div_idx <= r_div_idx + 2'd1;
                    case (r_div_idx)
                        2'd0: r_min_c <= lo_c;
                        2'd1: begin
                            r_max_c <= hi_c;
                            r_empty <= r_empty || up_empty;
                        end
                        2'd2: r_min_r <= lo_r;
                        default: begin
                            r_max_r <= hi_r;
                            r_empty <= r_empty || up_empty;
                        end
                    endcase
                end
            end
            ogsr_pkg::S_BOUNDS: begin
                r_r        <= r_min_r;
                r_x0_first <= (ogsr_pkg::POS_W)'(r_min_c) *
                              (ogsr_pkg::POS_W)'(i_cfg.cell_size);
                r_y0       <= (ogsr_pkg::POS_W)'(r_min_r) *
                              (ogsr_pkg::POS_W)'(i_cfg.cell_size);
                r_r2       <= (ogsr_pkg::R2_W)'(r_item.ex) * (ogsr_pkg::R2_W)'(r_item.ex);
            end
            ogsr_pkg::S_ROW_START: begin
                r_c    <= r_min_c;
                r_x0   <= r_x0_first;
                r_mask <= r_item.circle ? '0 : box_mask;
            end
            ogsr_pkg::S_CELL_D: begin
                r_dx <= (ogsr_pkg::DM_W)'(dx);
                r_dy <= (ogsr_pkg::DM_W)'(dy);
            end
            ogsr_pkg::S_CELL_SQ: begin
                r_dx2 <= (ogsr_pkg::SQ_W)'(r_dx) * (ogsr_pkg::SQ_W)'(r_dx);
                r_dy2 <= (ogsr_pkg::SQ_W)'(r_dy) * (ogsr_pkg::SQ_W)'(r_dy);
            end
            ogsr_pkg::S_CELL_CMP: begin
                if (hit) begin
                    r_mask[r_c[ogsr_pkg::COL_W-1:0]] <= 1'b1;
                end
                if (!last_col) begin
                    r_c  <= r_c + (ogsr_pkg::CB_W)'(1);
                    r_x0 <= r_x0 + (ogsr_pkg::POS_W)'(i_cfg.cell_size);
                end
            end
            ogsr_pkg::S_ROW_WR: begin
                if (!last_row) begin
                    r_r  <= r_r + (ogsr_pkg::RB_W)'(1);
                    r_y0 <= r_y0 + (ogsr_pkg::POS_W)'(i_cfg.cell_size);
                end
            end
            ogsr_pkg::S_READ: begin
                r_res.blocked <= r_valid[r_item.row] && r_rd_data[r_item.col];
            end
            default: begin
            end
        endcase
    end

    // Map memory: one row word per address, read data registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        if (r_state == ogsr_pkg::S_ROW_WR) begin
            mem[r_r[ogsr_pkg::ROW_W-1:0]] <=
                (r_valid[r_r[ogsr_pkg::ROW_W-1:0]] ? r_rd_data : '0) | r_mask;
        end
    end

    `OGSR_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == ogsr_pkg::S_DIV)
    `OGSR_ASSERT_NXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != ogsr_pkg::S_IDLE)
    `OGSR_ASSERT_IMP(a_row_in_bounds, i_clk, i_rst_n, r_state == ogsr_pkg::S_ROW_WR, r_r >= r_min_r && r_r <= r_max_r)
    `OGSR_ASSERT_IMP(a_col_in_bounds, i_clk, i_rst_n, r_state == ogsr_pkg::S_CELL_CMP, r_c >= r_min_c && r_c <= r_max_c)

endmodule

// ----- sv/occupancy_grid_shape_rasterizer.sv -----
// Clear and null items pass IDLE and DONE on their way to the result queue; a cell read adds READ.
// A shape runs the shared bit-serial divider four times, then walks its rows:
// a box row passes ROW_START, ROW_RD and ROW_WR; a circle adds CELL_D, CELL_SQ and CELL_CMP per cell.
// The back end takes one item at a time.
// Reset is synchronous and active low; the map reads clear at once through per-row valid bits.
// Registers return to their documented reset values; no clearing pass is needed.
module occupancy_grid_shape_rasterizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ogsr_pkg::ADDR_W-1:0]       paddr,
    input  logic [ogsr_pkg::DATA_W-1:0]       pwdata,
    output logic [ogsr_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic [ogsr_pkg::MODE_W-1:0]       i_mode,
    input  logic                              i_shape_kind,
    input  logic signed [ogsr_pkg::CRD_W-1:0] i_center_x,
    input  logic signed [ogsr_pkg::CRD_W-1:0] i_center_y,
    input  logic [ogsr_pkg::HALF_W-1:0]       i_half_x,
    input  logic [ogsr_pkg::HALF_W-1:0]       i_half_y,
    input  logic [ogsr_pkg::LAYER_W-1:0]      i_layer,
    input  logic [ogsr_pkg::SEL_W-1:0]        i_cell_col,
    input  logic [ogsr_pkg::SEL_W-1:0]        i_cell_row,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_blocked,
    output logic                              o_applied
);

    logic signed [ogsr_pkg::CRD_W-1:0]  r_origin_x;
    logic signed [ogsr_pkg::CRD_W-1:0]  r_origin_y;
    logic [ogsr_pkg::CS_W-1:0]          r_cell_size;
    logic [ogsr_pkg::SIZE_W-1:0]        r_width;
    logic [ogsr_pkg::SIZE_W-1:0]        r_height;
    logic [ogsr_pkg::LAYER_W-1:0]       r_layer_mask;
    logic [2:0]                         reg_idx;
    logic                               cfg_wr;
    ogsr_pkg::t_cfg                     cfg;

    logic                               item_valid;
    ogsr_pkg::t_item                    item;
    logic                               item_pop;
    logic                               res_push;
    ogsr_pkg::t_res                     res;
    ogsr_pkg::t_res                     r_oq [2];
    logic                               r_owp;
    logic                               r_orp;
    logic [1:0]                         r_ocnt;
    logic                               res_full;
    logic                               res_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_cell_size  <= (ogsr_pkg::CS_W)'(4096);
            r_width      <= (ogsr_pkg::SIZE_W)'(64);
            r_height     <= (ogsr_pkg::SIZE_W)'(64);
            r_layer_mask <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ogsr_pkg::REG_ORIGIN_X:   r_origin_x   <= signed'(pwdata[ogsr_pkg::CRD_W-1:0]);
                ogsr_pkg::REG_ORIGIN_Y:   r_origin_y   <= signed'(pwdata[ogsr_pkg::CRD_W-1:0]);
                ogsr_pkg::REG_CELL_SIZE:  r_cell_size  <= pwdata[ogsr_pkg::CS_W-1:0];
                ogsr_pkg::REG_WIDTH:      r_width      <= pwdata[ogsr_pkg::SIZE_W-1:0];
                ogsr_pkg::REG_HEIGHT:     r_height     <= pwdata[ogsr_pkg::SIZE_W-1:0];
                ogsr_pkg::REG_LAYER_MASK: r_layer_mask <= pwdata[ogsr_pkg::LAYER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            ogsr_pkg::REG_ORIGIN_X:   prdata = (ogsr_pkg::DATA_W)'(unsigned'(r_origin_x));
            ogsr_pkg::REG_ORIGIN_Y:   prdata = (ogsr_pkg::DATA_W)'(unsigned'(r_origin_y));
            ogsr_pkg::REG_CELL_SIZE:  prdata = (ogsr_pkg::DATA_W)'(r_cell_size);
            ogsr_pkg::REG_WIDTH:      prdata = (ogsr_pkg::DATA_W)'(r_width);
            ogsr_pkg::REG_HEIGHT:     prdata = (ogsr_pkg::DATA_W)'(r_height);
            ogsr_pkg::REG_LAYER_MASK: prdata = (ogsr_pkg::DATA_W)'(r_layer_mask);
            default:                  prdata = '0;
        endcase
    end

    // Effective grid settings: a zero cell size acts as one, sizes saturate to capacity.
    always_comb begin
        cfg.origin_x   = r_origin_x;
        cfg.origin_y   = r_origin_y;
        cfg.cell_size  = (r_cell_size == '0) ? (ogsr_pkg::CS_W)'(1) : r_cell_size;
        cfg.cols       = (int'(r_width) > ogsr_pkg::MAX_COLS) ?
                         (ogsr_pkg::CB_W)'(ogsr_pkg::MAX_COLS) : (ogsr_pkg::CB_W)'(r_width);
        cfg.rows       = (int'(r_height) > ogsr_pkg::MAX_ROWS) ?
                         (ogsr_pkg::RB_W)'(ogsr_pkg::MAX_ROWS) : (ogsr_pkg::RB_W)'(r_height);
        cfg.layer_mask = r_layer_mask;
    end

    ogsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .i_mode       (i_mode),
        .i_shape_kind (i_shape_kind),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_half_x     (i_half_x),
        .i_half_y     (i_half_y),
        .i_layer      (i_layer),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .o_full       (full),
        .o_valid      (item_valid),
        .o_item       (item),
        .i_pop        (item_pop)
    );

    ogsr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (item_valid),
        .i_item     (item),
        .o_pop      (item_pop),
        .o_res_push (res_push),
        .o_res      (res),
        .i_res_full (res_full)
    );

    // Two-entry result queue.
    assign res_full  = r_ocnt == 2'd2;
    assign empty     = r_ocnt == 2'd0;
    assign res_pop   = pop && !empty;
    assign o_blocked = r_oq[r_orp].blocked;
    assign o_applied = r_oq[r_orp].applied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (res_push) begin
                r_owp <= ~r_owp;
            end
            if (res_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, res_push} - {1'b0, res_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owp] <= res;
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import ogsr_pkg::*;

    // One input transaction as the sender sees it.
    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic                    kind;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic [HALF_W-1:0]       hx;
        logic [HALF_W-1:0]       hy;
        logic [LAYER_W-1:0]      layer;
        logic [SEL_W-1:0]        col;
        logic [SEL_W-1:0]        row;
    } t_grid_item;

    typedef struct {
        logic blocked;
        logic applied;
    } t_grid_answer;

    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic [MODE_W-1:0] i_mode = '0;
    logic i_shape_kind = 1'b0;
    logic signed [CRD_W-1:0] i_center_x = '0;
    logic signed [CRD_W-1:0] i_center_y = '0;
    logic [HALF_W-1:0] i_half_x = '0;
    logic [HALF_W-1:0] i_half_y = '0;
    logic [LAYER_W-1:0] i_layer = '0;
    logic [SEL_W-1:0] i_cell_col = '0;
    logic [SEL_W-1:0] i_cell_row = '0;
    logic empty;
    logic pop = 1'b0;
    logic o_blocked;
    logic o_applied;

    occupancy_grid_shape_rasterizer DUT (.*);

    // Shadow copy of the grid and its registers.
    bit occ_map [MAX_ROWS][MAX_COLS];
    longint grid_ox, grid_oy;
    int unsigned grid_cs, grid_w, grid_h, grid_mask;

    t_grid_answer grid_answers[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #100000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint ceil_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a > 0) q = q + 1;
        return q;
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Applies one item to the shadow grid and returns the answer it gives.
    function automatic t_grid_answer apply_grid_item(t_grid_item it);
        t_grid_answer ans;
        longint cs, w, h, rx, ry, ex, ey, r2;
        longint min_c, max_c, min_r, max_r, x0, y0, dx, dy;
        ans = '{1'b0, 1'b0};
        cs = (grid_cs == 0) ? 1 : longint'(grid_cs);
        w = (grid_w > MAX_COLS) ? MAX_COLS : longint'(grid_w);
        h = (grid_h > MAX_ROWS) ? MAX_ROWS : longint'(grid_h);
        case (it.mode)
            MODE_CLEAR: begin
                foreach (occ_map[r, c]) occ_map[r][c] = 1'b0;
            end
            MODE_SHAPE: begin
                if ((it.layer & grid_mask) != 0) begin
                    ans.applied = 1'b1;
                    rx = longint'(it.cx) - grid_ox;
                    ry = longint'(it.cy) - grid_oy;
                    ex = longint'(it.hx);
                    ey = (it.kind == KIND_CIRCLE) ? longint'(it.hx) : longint'(it.hy);
                    r2 = longint'(it.hx) * longint'(it.hx);
                    min_c = floor_quot(rx - ex, cs);
                    max_c = ceil_quot(rx + ex, cs) - 1;
                    min_r = floor_quot(ry - ey, cs);
                    max_r = ceil_quot(ry + ey, cs) - 1;
                    if (min_c < 0) min_c = 0;
                    if (min_r < 0) min_r = 0;
                    if (max_c > w - 1) max_c = w - 1;
                    if (max_r > h - 1) max_r = h - 1;
                    for (longint r = min_r; r <= max_r; r++) begin
                        for (longint c = min_c; c <= max_c; c++) begin
                            x0 = c * cs;
                            y0 = r * cs;
                            dx = clamp_to(rx, x0, x0 + cs) - rx;
                            dy = clamp_to(ry, y0, y0 + cs) - ry;
                            if (it.kind == KIND_BOX || dx * dx + dy * dy <= r2)
                                occ_map[r][c] = 1'b1;
                        end
                    end
                end
            end
            MODE_READ: begin
                if (longint'(it.col) < w && longint'(it.row) < h)
                    ans.blocked = occ_map[it.row][it.col];
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compares each accepted result with the oldest expected answer.
    always @(posedge i_clk) begin
        t_grid_answer exp_ans;
        if (i_rst_n && pop && !empty) begin
            if (grid_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: blocked=%0b applied=%0b",
                             o_blocked, o_applied);
            end else begin
                exp_ans = grid_answers.pop_front();
                if (exp_ans.blocked !== o_blocked || exp_ans.applied !== o_applied) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: expected blocked=%0b applied=%0b, got %0b %0b",
                                 $time, exp_ans.blocked, exp_ans.applied, o_blocked, o_applied);
                end
            end
        end
    end

    // Sends one item, sometimes after a random gap, and records its answer.
    task automatic send_item(t_grid_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= it.mode;
        i_shape_kind <= it.kind;
        i_center_x <= it.cx;
        i_center_y <= it.cy;
        i_half_x <= it.hx;
        i_half_y <= it.hy;
        i_layer <= it.layer;
        i_cell_col <= it.col;
        i_cell_row <= it.row;
        do @(posedge i_clk); while (full);
        grid_answers.push_back(apply_grid_item(it));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (grid_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register through the configuration port; the block is idle.
    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X:   grid_ox = longint'($signed(val[CRD_W-1:0]));
            REG_ORIGIN_Y:   grid_oy = longint'($signed(val[CRD_W-1:0]));
            REG_CELL_SIZE:  grid_cs = 32'(val[CS_W-1:0]);
            REG_WIDTH:      grid_w = 32'(val[SIZE_W-1:0]);
            REG_HEIGHT:     grid_h = 32'(val[SIZE_W-1:0]);
            REG_LAYER_MASK: grid_mask = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(int ox, int oy, int cs, int w, int h, int unsigned mask);
        drain_results();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LAYER_MASK, mask);
    endtask

    function automatic t_grid_item make_item(logic [MODE_W-1:0] mode, logic kind,
                                             int cx, int cy, int hx, int hy,
                                             int unsigned layer, int col, int row);
        t_grid_item it;
        it.mode = mode;
        it.kind = kind;
        it.cx = CRD_W'(cx);
        it.cy = CRD_W'(cy);
        it.hx = HALF_W'(hx);
        it.hy = HALF_W'(hy);
        it.layer = layer;
        it.col = SEL_W'(col);
        it.row = SEL_W'(row);
        return it;
    endfunction

    // Extremes of the fields, every mode and the named special cases.
    task automatic test_directed();
        set_grid(0, 0, 4096, 64, 64, 0);
        send_item(make_item(MODE_SHAPE, KIND_BOX, 8192, 8192, 4096, 4096, 32'hFFFF_FFFF, 0, 0));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 0, 0));
        drain_results();
        write_reg(REG_LAYER_MASK, 32'h0000_0100);
        send_item(make_item(MODE_SHAPE, KIND_BOX, 8192, 8192, 4096, 4096, 32'h0000_0300, 0, 0));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 1, 1));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 2, 2));
        send_item(make_item(MODE_SHAPE, KIND_CIRCLE, 40960, 40960, 6000, 0, 32'h100, 0, 0));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 10, 10));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 11, 11));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 8, 8));
        // Shape far outside the grid: empty bounds, still applied.
        send_item(make_item(MODE_SHAPE, KIND_BOX, -8388608, -8388608, 0, 0, 32'h100, 0, 0));
        send_item(make_item(MODE_SHAPE, KIND_BOX, 8388607, -8388608, 8388607, 8388607,
                            32'hFFFF_FFFF, 0, 0));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 63, 63));
        send_item(make_item(MODE_UNUSED, KIND_CIRCLE, -1, -1, 8388607, 8388607,
                            32'hFFFF_FFFF, 63, 63));
        send_item(make_item(MODE_CLEAR, KIND_CIRCLE, 8388607, 8388607, 8388607, 8388607,
                            32'hFFFF_FFFF, 63, 63));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 63, 63));
        send_item(make_item(MODE_SHAPE, KIND_CIRCLE, 8388607, 8388607, 8388607, 0,
                            32'h100, 0, 0));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 0, 63));
        send_item(make_item(MODE_SHAPE, KIND_CIRCLE, 4096, 4096, 0, 0, 32'h100, 0, 0));
        // Shrink the grid: marked cells outside read as clear, then come back.
        drain_results();
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 0);
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_SHAPE, KIND_BOX, 0, 0, 65536, 65536, 32'h100, 0, 0));
        drain_results();
        write_reg(REG_HEIGHT, 64);
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 0, 5));
        send_item(make_item(MODE_READ, KIND_BOX, 0, 0, 0, 0, 0, 5, 5));
    endtask

    // Random items around the current grid, mostly small shapes.
    function automatic t_grid_item random_item();
        t_grid_item it;
        longint cs, span, v;
        int pick;
        cs = (grid_cs == 0) ? 1 : longint'(grid_cs);
        pick = $urandom_range(99);
        if (pick < 5) begin
            it = make_item(MODE_W'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            return it;
        end
        span = cs * 72;
        it.mode = (pick < 9) ? MODE_CLEAR : (pick < 11) ? MODE_UNUSED :
                  (pick < 55) ? MODE_SHAPE : MODE_READ;
        it.kind = 1'($urandom);
        v = grid_ox + longint'($urandom_range(0, 32'(span))) - 4 * cs;
        it.cx = CRD_W'(v);
        v = grid_oy + longint'($urandom_range(0, 32'(span))) - 4 * cs;
        it.cy = CRD_W'(v);
        if ($urandom_range(99) < 3) begin
            it.hx = HALF_W'($urandom);
            it.hy = HALF_W'($urandom);
        end else begin
            v = longint'($urandom_range(0, 32'(3 * cs)));
            it.hx = (v > 8388607) ? 23'h7FFFFF : HALF_W'(v);
            v = longint'($urandom_range(0, 32'(3 * cs)));
            it.hy = (v > 8388607) ? 23'h7FFFFF : HALF_W'(v);
        end
        it.layer = ($urandom_range(3) == 0) ? $urandom : (grid_mask | $urandom);
        it.col = SEL_W'($urandom);
        it.row = SEL_W'($urandom);
        return it;
    endfunction

    task automatic random_burst(int n, bit pause_to_drain);
        for (int k = 0; k < n; k++) begin
            if (pause_to_drain && k % 60 == 59) drain_results();
            send_item(random_item());
        end
    endtask

    // Each idling pattern runs over several grid settings, the extremes among them.
    task automatic test_random(int s_idle, int r_idle, bit pause_to_drain);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        set_grid(0, 0, 4096, 64, 64, 32'hFFFF_FFFF);
        random_burst(110, pause_to_drain);
        set_grid(-3000, 1234, 700, 40, 23, 32'h0000_00F0);
        random_burst(90, pause_to_drain);
        set_grid(-8388608, -8388608, 1, 127, 127, 32'h0000_0001);
        random_burst(70, pause_to_drain);
        set_grid(8388607, -8388608, 1048575, 1, 64, $urandom);
        random_burst(70, pause_to_drain);
        set_grid(100, -100, 0, 0, 5, 32'hFFFF_FFFF);
        random_burst(40, pause_to_drain);
        set_grid(-512, 512, 300, 64, 64, 32'h8000_0000);
        random_burst(95, pause_to_drain);
    endtask

    initial begin
        grid_ox = 0;
        grid_oy = 0;
        grid_cs = 4096;
        grid_w = 64;
        grid_h = 64;
        grid_mask = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(9, 46, 1'b0);
        test_random(46, 9, 1'b1);
        test_random(0, 0, 1'b0);
        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && grid_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/ogsr_pkg.sv
sv/ogsr_div.sv
sv/ogsr_front.sv
sv/ogsr_back.sv
sv/occupancy_grid_shape_rasterizer.sv
tb/tb.sv
